### rtl/core/osps_pkg.sv
// Shared types, constants and saturation helpers for the octave-up shimmer.
package osps_pkg;

  localparam int SW = 24;
  localparam int FW = SW + 4;
  localparam int GW = 2048;
  localparam int PW = 11;
  localparam int WW = 24;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_FEED    = 2'd1;
  localparam logic [1:0] ACT_CAPTURE = 2'd2;
  localparam logic [1:0] ACT_SPARE   = 2'd3;

  localparam logic [23:0] GAIN_055   = 24'd9227469;
  localparam logic [12:0] SMOOTH     = 13'd3277;
  localparam logic [23:0] OFF_THRESH = 24'd1678;
  localparam logic [15:0] LP_COEF    = 16'd31457;
  localparam logic [15:0] HP_COEF    = 16'd63898;

  localparam logic signed [33:0] SINE_C [0:4] = '{
    34'sd1686629713, -34'sd693598669, 34'sd85569306, -34'sd5026995, 34'sd172272
  };

  typedef logic signed [SW-1:0] sample_t;
  typedef logic signed [FW-1:0] filt_t;
  typedef logic [WW-1:0]        window_t;
  typedef logic [PW-1:0]        phase_t;
  typedef logic [23:0]          gain_t;

  typedef struct packed {
    logic start;
    logic ok0;
    logic ok1;
  } lane_cmd_t;

  function automatic filt_t sat_filt(input logic signed [29:0] v);
    if (v > 30'sd134217727) begin
      return 28'sh7FFFFFF;
    end else if (v < -30'sd134217728) begin
      return 28'sh8000000;
    end
    return v[27:0];
  endfunction

  function automatic sample_t sat_sample(input logic signed [29:0] v);
    if (v > 30'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -30'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

### rtl/core/osps_if.sv
// Handshake channels of the shimmer: input items, results and the config write.
interface osps_in_if;
  import osps_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  sample_t    sample_left;
  sample_t    sample_right;
  modport source(output valid, action, sample_left, sample_right, input ready);
  modport sink(input valid, action, sample_left, sample_right, output ready);
endinterface

interface osps_out_if;
  import osps_pkg::*;
  logic    valid;
  logic    ready;
  sample_t send_out_left;
  sample_t send_out_right;
  modport source(output valid, send_out_left, send_out_right, input ready);
  modport sink(input valid, send_out_left, send_out_right, output ready);
endinterface

interface osps_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] shimmer_amount;
  modport source(output valid, shimmer_amount, input ready);
  modport sink(input valid, shimmer_amount, output ready);
endinterface

### rtl/core/octave_up_shimmer_pitch_shifter_core.sv
// Top level of the octave-up shimmer: sequencer, gain smoothing and result merge.
//
// Channels: in_ch takes one item per transaction (action, sample_left,
// sample_right); out_ch returns one result per feed transaction; cfg_ch writes
// shimmer_amount and is always ready. Configuration must be written while
// idle; the block does not enforce it. Block start squares the amount,
// scales it to the gain target and smooths the gain. A capture is done in
// the accepting cycle. A bypassed feed goes via the result register and the
// delivery state to the output register. Otherwise a feed runs two ten-step
// polynomial evaluations in the shared window unit, then both lanes in parallel
// do two ring reads through their single read port and a six-step filter and
// gain chain. Items are processed one at a time; a new item is accepted as
// soon as the previous one has handed its result to the output register.
// If the receiver stalls, the result waits in the output register and the
// next item still runs, but a further result waits until the slot frees.
// Reset clears the gain, filters and indexes and sets bypass; unwritten ring
// entries read as zero through a fill count, so no clearing pass is needed.
module octave_up_shimmer_pitch_shifter_core #(
  parameter int RING_DEPTH = 4096,
  parameter int READ_GUARD = 260
) (
  input logic        clk,
  input logic        rst_n,
  osps_in_if.sink    in_ch,
  osps_out_if.source out_ch,
  osps_cfg_if.sink   cfg_ch
);
  import osps_pkg::*;

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int FCW  = $clog2(RING_DEPTH + 1);
  localparam int KOFF = (GW + READ_GUARD) % RING_DEPTH;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_TGT, S_DIFF, S_GUPD, S_WIN0, S_WIN1, S_LANE, S_DLV
  } state_t;

  state_t             state_r;
  logic [15:0]        amt_r;
  logic [AW-1:0]      wi_r;
  logic [AW-1:0]      fo_r;
  phase_t             gp_r;
  gain_t              gain_r;
  logic               byp_r;
  logic [FCW-1:0]     fill_r;
  logic [31:0]        sq_r;
  gain_t              tgt_r;
  logic signed [38:0] dprod_r;
  window_t            w0_r;
  window_t            w1_r;
  sample_t            send_l_r;
  sample_t            send_r_r;
  sample_t            res_l_r;
  sample_t            res_r_r;
  logic               out_valid_r;
  sample_t            out_l_r;
  sample_t            out_rt_r;

  logic               in_acc;
  logic               win_start;
  phase_t             win_phase;
  logic               win_done;
  window_t            win_w;
  logic [AW:0]        base_sum;
  logic [AW-1:0]      base;
  logic [AW-1:0]      i0;
  logic [AW-1:0]      i1;
  lane_cmd_t          cmd;
  logic               wr_en;
  logic               lane_l_done;
  logic               lane_r_done;
  sample_t            lane_l_res;
  sample_t            lane_r_res;
  logic [55:0]        tprod;
  logic signed [38:0] gr;
  logic signed [25:0] gsum;
  gain_t              g_nxt;

  function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] b, input phase_t p);
    logic [AW:0] a;
    a = {1'b0, b} + (AW+1)'(p);
    if (a >= (AW+1)'(RING_DEPTH)) begin
      a = a - (AW+1)'(RING_DEPTH);
    end
    if (a >= (AW+1)'(KOFF)) begin
      a = a - (AW+1)'(KOFF);
    end else begin
      a = a + (AW+1)'(RING_DEPTH - KOFF);
    end
    return a[AW-1:0];
  endfunction

  always_comb begin
    in_acc    = in_ch.valid && in_ch.ready;
    wr_en     = in_acc && (in_ch.action == ACT_CAPTURE) && !byp_r;
    win_start = (in_acc && (in_ch.action == ACT_FEED) && !byp_r) ||
                ((state_r == S_WIN0) && win_done);
    win_phase = (state_r == S_IDLE) ? gp_r + phase_t'(1) : gp_r + phase_t'(GW / 2);
    base_sum  = {1'b0, wi_r} + {1'b0, fo_r};
    base      = (base_sum >= (AW+1)'(RING_DEPTH)) ?
                AW'(base_sum - (AW+1)'(RING_DEPTH)) : base_sum[AW-1:0];
    i0        = tap_addr(base, gp_r);
    i1        = tap_addr(base, gp_r + phase_t'(GW / 2));
    cmd.start = (state_r == S_WIN1) && win_done;
    cmd.ok0   = FCW'(i0) < fill_r;
    cmd.ok1   = FCW'(i1) < fill_r;
    tprod     = sq_r * GAIN_055;
    gr        = (dprod_r + 39'sd32768) >>> 16;
    gsum      = $signed({2'b00, gain_r}) + gr[25:0];
    if (gsum < 26'sd0) begin
      g_nxt = '0;
    end else if (gsum > 26'sd16777215) begin
      g_nxt = 24'hFFFFFF;
    end else begin
      g_nxt = gsum[23:0];
    end
  end

  osps_win u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .start (win_start),
    .phase (win_phase),
    .done  (win_done),
    .w     (win_w)
  );

  osps_lane #(.DEPTH(RING_DEPTH), .AW(AW)) u_lane_l (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_i0   (i0),
    .rd_i1   (i1),
    .w0      (w0_r),
    .w1      (w1_r),
    .gain    (gain_r),
    .send    (send_l_r),
    .wr_en   (wr_en),
    .wr_addr (wi_r),
    .wr_data (in_ch.sample_left),
    .done    (lane_l_done),
    .result  (lane_l_res)
  );

  osps_lane #(.DEPTH(RING_DEPTH), .AW(AW)) u_lane_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_i0   (i0),
    .rd_i1   (i1),
    .w0      (w0_r),
    .w1      (w1_r),
    .gain    (gain_r),
    .send    (send_r_r),
    .wr_en   (wr_en),
    .wr_addr (wi_r),
    .wr_data (in_ch.sample_right),
    .done    (lane_r_done),
    .result  (lane_r_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      amt_r       <= '0;
      wi_r        <= '0;
      fo_r        <= '0;
      gp_r        <= '0;
      gain_r      <= '0;
      byp_r       <= 1'b1;
      fill_r      <= '0;
      sq_r        <= '0;
      tgt_r       <= '0;
      dprod_r     <= '0;
      w0_r        <= '0;
      w1_r        <= '0;
      send_l_r    <= '0;
      send_r_r    <= '0;
      res_l_r     <= '0;
      res_r_r     <= '0;
      out_valid_r <= 1'b0;
      out_l_r     <= '0;
      out_rt_r    <= '0;
    end else begin
      if (cfg_ch.valid) begin
        amt_r <= cfg_ch.shimmer_amount;
      end
      // A waiting result in the delivery state is replaced there, not cleared here.
      if (out_valid_r && out_ch.ready && (state_r != S_DLV)) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        wi_r <= (wi_r == AW'(RING_DEPTH - 1)) ? '0 : wi_r + AW'(1);
        if (fill_r != FCW'(RING_DEPTH)) begin
          fill_r <= fill_r + FCW'(1);
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            send_l_r <= in_ch.sample_left;
            send_r_r <= in_ch.sample_right;
            case (in_ch.action)
              ACT_START: state_r <= S_SQ;
              ACT_FEED: begin
                if (byp_r) begin
                  res_l_r <= in_ch.sample_left;
                  res_r_r <= in_ch.sample_right;
                  state_r <= S_DLV;
                end else begin
                  gp_r    <= win_phase;
                  state_r <= S_WIN0;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SQ: begin
          sq_r    <= amt_r * amt_r;
          state_r <= S_TGT;
        end
        S_TGT: begin
          tgt_r   <= tprod[55:32];
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          dprod_r <= ($signed({1'b0, tgt_r}) - $signed({1'b0, gain_r})) *
                     $signed({1'b0, SMOOTH});
          state_r <= S_GUPD;
        end
        S_GUPD: begin
          gain_r  <= g_nxt;
          byp_r   <= (g_nxt < OFF_THRESH) && (tgt_r < OFF_THRESH);
          fo_r    <= '0;
          state_r <= S_IDLE;
        end
        S_WIN0: begin
          if (win_done) begin
            w0_r    <= win_w;
            state_r <= S_WIN1;
          end
        end
        S_WIN1: begin
          if (win_done) begin
            w1_r    <= win_w;
            state_r <= S_LANE;
          end
        end
        S_LANE: begin
          if (lane_l_done) begin
            res_l_r <= lane_l_res;
            res_r_r <= lane_r_res;
            fo_r    <= (fo_r == AW'(RING_DEPTH - 1)) ? '0 : fo_r + AW'(1);
            state_r <= S_DLV;
          end
        end
        S_DLV: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_l_r     <= res_l_r;
            out_rt_r    <= res_r_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.send_out_left  = out_l_r;
  assign out_ch.send_out_right = out_rt_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FCW'(RING_DEPTH))
    else $error("ring fill count ran past the ring depth");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lane_l_done == lane_r_done)
    else $error("left and right lanes finished in different cycles");

  a_lane_not_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LANE) |-> !byp_r)
    else $error("lanes running while bypass is set");

  a_win_done_place: assert property (@(posedge clk) disable iff (!rst_n)
    win_done |-> (state_r == S_WIN0 || state_r == S_WIN1))
    else $error("window result arrived outside a window wait state");

  a_capture_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && wi_r != AW'(RING_DEPTH - 1)) |=> (wi_r == $past(wi_r) + AW'(1)))
    else $error("write index did not advance after a capture");

endmodule

### rtl/core/osps_win.sv
// Sine window unit: Horner evaluation of the odd polynomial.
module osps_win (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  osps_pkg::phase_t phase,
  output logic             done,
  output osps_pkg::window_t w
);
  import osps_pkg::*;

  typedef enum logic [2:0] {W_IDLE, W_MUL, W_ADD, W_FMUL, W_FIN} wstate_t;

  wstate_t              state_r;
  logic [10:0]          m_r;
  logic signed [31:0]   u2_r;
  logic signed [33:0]   t_r;
  logic signed [65:0]   prod_r;
  logic [2:0]           k_r;
  logic                 done_r;
  window_t              w_r;

  logic [11:0]          rest;
  logic [10:0]          m_nxt;
  logic [21:0]          msq;
  logic signed [65:0]   rnd30;
  logic signed [65:0]   fin;
  logic [30:0]          clamped;
  logic [31:0]          wsum;

  always_comb begin
    rest    = 12'(GW) - {1'b0, phase};
    m_nxt   = ({1'b0, phase} <= rest) ? phase : rest[10:0];
    msq     = 22'(m_nxt) * 22'(m_nxt);
    rnd30   = (prod_r + (66'sd1 <<< 29)) >>> 30;
    fin     = (prod_r + 66'sd512) >>> 10;
    if (fin < 66'sd0) begin
      clamped = '0;
    end else if (fin > (66'sd1 <<< 30)) begin
      clamped = 31'd1 << 30;
    end else begin
      clamped = fin[30:0];
    end
    wsum = {1'b0, clamped} + 32'd64;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      done_r  <= 1'b0;
      m_r     <= '0;
      u2_r    <= '0;
      t_r     <= '0;
      prod_r  <= '0;
      k_r     <= '0;
      w_r     <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        W_IDLE: begin
          if (start) begin
            m_r     <= m_nxt;
            u2_r    <= {msq, 10'b0};
            t_r     <= SINE_C[4];
            k_r     <= 3'd3;
            state_r <= W_MUL;
          end
        end
        W_MUL: begin
          prod_r  <= u2_r * t_r;
          state_r <= W_ADD;
        end
        W_ADD: begin
          t_r <= SINE_C[k_r] + rnd30[33:0];
          if (k_r == 3'd0) begin
            state_r <= W_FMUL;
          end else begin
            k_r     <= k_r - 3'd1;
            state_r <= W_MUL;
          end
        end
        W_FMUL: begin
          prod_r  <= $signed({1'b0, m_r}) * t_r;
          state_r <= W_FIN;
        end
        W_FIN: begin
          w_r     <= wsum[30:7];
          done_r  <= 1'b1;
          state_r <= W_IDLE;
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign w    = w_r;

endmodule

### rtl/core/osps_lane.sv
// One channel lane: ring buffer, two-tap windowed mix, filters and gain.
module osps_lane #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  osps_pkg::lane_cmd_t cmd,
  input  logic [AW-1:0]      rd_i0,
  input  logic [AW-1:0]      rd_i1,
  input  osps_pkg::window_t  w0,
  input  osps_pkg::window_t  w1,
  input  osps_pkg::gain_t    gain,
  input  osps_pkg::sample_t  send,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  osps_pkg::sample_t  wr_data,
  output logic               done,
  output osps_pkg::sample_t  result
);
  import osps_pkg::*;

  typedef enum logic [2:0] {
    L_IDLE, L_TAP1, L_MUL, L_MAC, L_FMUL, L_FILT, L_GMUL, L_OUT
  } lstate_t;

  sample_t            ring_r [DEPTH];
  sample_t            rdata_r;
  lstate_t            state_r;
  sample_t            t0_r;
  logic signed [48:0] pa_r;
  logic signed [48:0] pb_r;
  logic signed [28:0] diff_r;
  logic signed [45:0] mlp_r;
  logic signed [44:0] mhp_r;
  logic signed [52:0] pg_r;
  filt_t              lp_r;
  filt_t              hx_r;
  filt_t              hy_r;
  sample_t            res_r;
  logic               done_r;

  logic [AW-1:0]      rd_addr;
  sample_t            t1;
  logic signed [49:0] s_w;
  logic signed [28:0] diff_nxt;
  logic signed [45:0] lpr;
  logic signed [44:0] hpr;
  filt_t              lp_nxt;
  filt_t              h_nxt;
  logic signed [52:0] gr;
  sample_t            res_nxt;

  always_comb begin
    rd_addr  = (state_r == L_IDLE) ? rd_i0 : rd_i1;
    t1       = cmd.ok1 ? rdata_r : '0;
    s_w      = (50'(pa_r) + 50'(pb_r) + (50'sd1 <<< 22)) >>> 23;
    diff_nxt = s_w[28:0] - 29'(lp_r);
    lpr      = (mlp_r + 46'sd32768) >>> 16;
    lp_nxt   = sat_filt(30'(lp_r) + lpr[29:0]);
    hpr      = (mhp_r + 45'sd32768) >>> 16;
    h_nxt    = sat_filt(30'(lp_nxt) - 30'(hx_r) + hpr[29:0]);
    gr       = (pg_r + (53'sd1 <<< 23)) >>> 24;
    res_nxt  = sat_sample(30'(send) + gr[29:0]);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= ring_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
      lp_r    <= '0;
      hx_r    <= '0;
      hy_r    <= '0;
      t0_r    <= '0;
      pa_r    <= '0;
      pb_r    <= '0;
      diff_r  <= '0;
      mlp_r   <= '0;
      mhp_r   <= '0;
      pg_r    <= '0;
      res_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (cmd.start) begin
            state_r <= L_TAP1;
          end
        end
        L_TAP1: begin
          t0_r    <= cmd.ok0 ? rdata_r : '0;
          state_r <= L_MUL;
        end
        L_MUL: begin
          pa_r    <= t0_r * $signed({1'b0, w0});
          pb_r    <= t1 * $signed({1'b0, w1});
          state_r <= L_MAC;
        end
        L_MAC: begin
          diff_r  <= diff_nxt;
          state_r <= L_FMUL;
        end
        L_FMUL: begin
          mlp_r   <= diff_r * $signed({1'b0, LP_COEF});
          mhp_r   <= hy_r * $signed({1'b0, HP_COEF});
          state_r <= L_FILT;
        end
        L_FILT: begin
          lp_r    <= lp_nxt;
          hx_r    <= lp_nxt;
          hy_r    <= h_nxt;
          state_r <= L_GMUL;
        end
        L_GMUL: begin
          pg_r    <= hy_r * $signed({1'b0, gain});
          state_r <= L_OUT;
        end
        L_OUT: begin
          res_r   <= res_nxt;
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
